// ----- rtl/lnw_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the log-correction table for the log-sum-exp
// wirelength block. Used by every module under lse_net_wirelength.
package lnw_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int CORR_DEPTH      = 256;

    localparam int COORD_W     = 28;
    localparam int CFG_W       = 32;
    localparam int ETA_FRAC    = 16;
    localparam int LOG_FRAC    = 8;
    localparam int STEP_SHIFT  = 3;
    localparam int LSUM_W      = 40;
    localparam int WL_W        = 40;
    localparam int NUM_DIR     = 4;
    localparam int SCALE_SHIFT = COORD_FRAC_BITS + ETA_FRAC - LOG_FRAC;
    localparam int PROD_W      = COORD_W + CFG_W;
    localparam int CORR_IDX_W  = $clog2(CORR_DEPTH);
    localparam int CORR_W      = 8;

    localparam int IN_DATA_W   = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((WL_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [LSUM_W-1:0] LSUM_MAX = {1'b0, {(LSUM_W-1){1'b1}}};
    localparam logic [WL_W-1:0]   WL_MAX   = '1;
    localparam logic [CFG_W-1:0]  CFG_ONE  = CFG_W'(65536);

    typedef enum logic [0:0] {
        CFG_ETA     = 1'b0,
        CFG_INV_ETA = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [LSUM_W-1:0] vx;
        logic signed [LSUM_W-1:0] vy;
        logic                     first;
        logic                     last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } push_t;

    typedef logic [CORR_DEPTH-1:0][CORR_W-1:0] corr_tab_t;

    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;
    localparam logic [63:0] LN2_Q30      = 64'd744261118;

    // log2 of z in [1,2] (Q.30), result Q.20, by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [63:0] zin);
        logic [63:0] z;
        logic [63:0] r;
        z = zin;
        r = '0;
        if (z >= 2 * Q30_ONE) begin
            r[20] = 1'b1;
            z = z >> 1;
        end
        for (int k = 19; k >= 0; k--) begin
            z = (z * z) >> 30;
            if (z >= 2 * Q30_ONE) begin
                r[k] = 1'b1;
                z = z >> 1;
            end
        end
        return r;
    endfunction

    // entry i = ln(1 + exp(-i/32)) in Q.8
    function automatic corr_tab_t build_corr_tab();
        corr_tab_t   tab;
        logic [63:0] e;
        logic [63:0] l2;
        logic [63:0] ln;
        e = Q30_ONE;
        for (int i = 0; i < CORR_DEPTH; i++) begin
            l2 = log2_q30(Q30_ONE + e);
            ln = (l2 * LN2_Q30 + (64'd1 << 41)) >> 42;
            tab[i] = ln[CORR_W-1:0];
            e = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam corr_tab_t CORR_TAB = build_corr_tab();

endpackage

// ----- rtl/lse_net_wirelength.sv -----
`timescale 1ns / 1ps
// Top level of the log-sum-exp net wirelength block: config registers and
// the front / queue / back chain. Depends on lnw_pkg, lnw_front, lnw_queue, lnw_back.
//
//  channel   dir   payload                          handshake
//  s_        in    tdata: center_x, center_y        tvalid/tready, tlast = last_pin
//  m_        out   tdata: net_wirelength            tvalid/tready, tuser = overflow
//  cfg_      in    index 0 eta_q, 1 inv_eta_q       valid/ready (ready always high)
//
// One pin per cycle in steady state, while s_tready is high and no last pin waits on
// the finalize: registered scaling stages a and b in the front, then the four-lane merge
// of the back end. A net's last pin starts a finalize through states PAIR, SUM, MUL and
// DONE (pair sums, total, split multiply by eta, truncate and saturate); another last
// pin waits for it. A stalled output holds the finalize; the 4-entry queue lets the
// front keep taking pins meanwhile. Reset is synchronous, no clearing pass.
module lse_net_wirelength (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lnw_pkg::IN_DATA_W-1:0]   s_tdata,   // [27:0] center_x, [55:28] center_y
    input  logic                            s_tlast,   // last_pin
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lnw_pkg::OUT_DATA_W-1:0]  m_tdata,   // [39:0] net_wirelength
    output logic [0:0]                      m_tuser,   // [0] overflow
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [lnw_pkg::CFG_W-1:0]       cfg_data
);

    logic [lnw_pkg::CFG_W-1:0]  eta_reg;
    logic [lnw_pkg::CFG_W-1:0]  eta_next;
    logic [lnw_pkg::CFG_W-1:0]  inv_eta_reg;
    logic [lnw_pkg::CFG_W-1:0]  inv_eta_next;
    lnw_pkg::push_t             push;
    logic                       pop;
    logic                       head_valid;
    lnw_pkg::q_entry_t          head;
    logic [lnw_pkg::QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_comb begin
        eta_next     = eta_reg;
        inv_eta_next = inv_eta_reg;
        if (cfg_valid) begin
            case (lnw_pkg::cfg_idx_t'(cfg_index))
                lnw_pkg::CFG_ETA:     eta_next     = cfg_data;
                lnw_pkg::CFG_INV_ETA: inv_eta_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_reg     <= lnw_pkg::CFG_ONE;
            inv_eta_reg <= lnw_pkg::CFG_ONE;
        end else begin
            eta_reg     <= eta_next;
            inv_eta_reg <= inv_eta_next;
        end
    end

    lnw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .inv_eta  (inv_eta_reg),
        .q_count  (q_count),
        .push     (push)
    );

    lnw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    lnw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .eta        (eta_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- rtl/lnw_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pins, marks net start/end, scales both coordinates by 1/eta.
// Depends on lnw_pkg; feeds lnw_queue.
module lnw_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lnw_pkg::IN_DATA_W-1:0]  s_tdata,   // center_x, center_y
    input  logic                           s_tlast,   // last_pin
    input  logic [lnw_pkg::CFG_W-1:0]      inv_eta,
    input  logic [lnw_pkg::QCNT_W-1:0]     q_count,
    output lnw_pkg::push_t                 push
);

    localparam int CW  = lnw_pkg::COORD_W;
    localparam int PW  = lnw_pkg::PROD_W;
    localparam int LW  = lnw_pkg::LSUM_W;
    localparam int OCC = lnw_pkg::QCNT_W + 1;

    logic              accept;
    logic [CW-1:0]     cx;
    logic [CW-1:0]     cy;
    logic [CW-1:0]     mag_x;
    logic [CW-1:0]     mag_y;
    logic [OCC-1:0]    occupancy;
    logic              net_open_reg;
    logic              net_open_next;

    logic              a_valid_reg;
    logic [CW-1:0]     a_mag_x_reg;
    logic [CW-1:0]     a_mag_y_reg;
    logic              a_neg_x_reg;
    logic              a_neg_y_reg;
    logic              a_first_reg;
    logic              a_last_reg;

    logic              b_valid_reg;
    logic [PW-1:0]     b_prod_x_reg;
    logic [PW-1:0]     b_prod_y_reg;
    logic              b_neg_x_reg;
    logic              b_neg_y_reg;
    logic              b_first_reg;
    logic              b_last_reg;

    function automatic logic signed [LW-1:0] round_sat(input logic [PW-1:0] prod,
                                                        input logic neg);
        logic [PW:0]   r;
        logic [PW:0]   q;
        logic [LW-1:0] m;
        r = {1'b0, prod} + ((PW + 1)'(1) << (lnw_pkg::SCALE_SHIFT - 1));
        q = r >> lnw_pkg::SCALE_SHIFT;
        if (q > {{(PW + 1 - LW){1'b0}}, lnw_pkg::LSUM_MAX}) begin
            m = lnw_pkg::LSUM_MAX;
        end else begin
            m = q[LW-1:0];
        end
        return neg ? -$signed(m) : $signed(m);
    endfunction

    assign cx        = s_tdata[CW-1:0];
    assign cy        = s_tdata[2*CW-1:CW];
    assign mag_x     = cx[CW-1] ? (~cx + CW'(1)) : cx;
    assign mag_y     = cy[CW-1] ? (~cy + CW'(1)) : cy;
    assign occupancy = OCC'(q_count) + OCC'(a_valid_reg) + OCC'(b_valid_reg);
    assign s_tready  = occupancy < OCC'(lnw_pkg::QUEUE_DEPTH);
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        net_open_next = net_open_reg;
        if (accept) begin
            net_open_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            net_open_reg <= 1'b0;
        end else begin
            a_valid_reg  <= accept;
            b_valid_reg  <= a_valid_reg;
            net_open_reg <= net_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_mag_x_reg <= mag_x;
            a_mag_y_reg <= mag_y;
            a_neg_x_reg <= cx[CW-1];
            a_neg_y_reg <= cy[CW-1];
            a_first_reg <= !net_open_reg;
            a_last_reg  <= s_tlast;
        end
        if (a_valid_reg) begin
            b_prod_x_reg <= PW'(a_mag_x_reg) * PW'(inv_eta);
            b_prod_y_reg <= PW'(a_mag_y_reg) * PW'(inv_eta);
            b_neg_x_reg  <= a_neg_x_reg;
            b_neg_y_reg  <= a_neg_y_reg;
            b_first_reg  <= a_first_reg;
            b_last_reg   <= a_last_reg;
        end
    end

    always_comb begin
        push.valid       = b_valid_reg;
        push.entry.vx    = round_sat(b_prod_x_reg, b_neg_x_reg);
        push.entry.vy    = round_sat(b_prod_y_reg, b_neg_y_reg);
        push.entry.first = b_first_reg;
        push.entry.last  = b_last_reg;
    end

endmodule

// ----- rtl/lnw_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of scaled pins between front and back end.
// Depends on lnw_pkg.
module lnw_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lnw_pkg::push_t             push,
    input  logic                       pop,
    output logic                       head_valid,
    output lnw_pkg::q_entry_t          head,
    output logic [lnw_pkg::QCNT_W-1:0] count
);

    localparam int PTRW = lnw_pkg::QPTR_W;
    localparam int CNTW = lnw_pkg::QCNT_W;

    lnw_pkg::q_entry_t mem [lnw_pkg::QUEUE_DEPTH];
    lnw_pkg::q_entry_t head_reg;
    logic [PTRW-1:0]   wr_ptr_reg;
    logic [PTRW-1:0]   wr_ptr_next;
    logic [PTRW-1:0]   rd_ptr_reg;
    logic [PTRW-1:0]   rd_ptr_next;
    logic [CNTW-1:0]   count_reg;
    logic [CNTW-1:0]   count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = wr_ptr_reg + PTRW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTRW'(1);
        end
        if (push.valid && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (!push.valid && pop) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head is read ahead from the next read pointer; a write into the next head slot bypasses
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.entry;
        end
        if (push.valid && wr_ptr_reg == rd_ptr_next) begin
            head_reg <= push.entry;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head       = head_reg;
    assign head_valid = count_reg != '0;
    assign count      = count_reg;

endmodule

// ----- rtl/lnw_back.sv -----
`timescale 1ns / 1ps
// Back end: four log-sum-exp lanes merged one pin per cycle, then a sequencer that
// sums lanes, multiplies by eta, saturates; last pins wait on it. Depends on lnw_pkg.
module lnw_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  lnw_pkg::q_entry_t               head,
    output logic                            pop,
    input  logic [lnw_pkg::CFG_W-1:0]       eta,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lnw_pkg::OUT_DATA_W-1:0]  m_tdata,   // net_wirelength
    output logic [0:0]                      m_tuser    // overflow
);

    localparam int LW    = lnw_pkg::LSUM_W;
    localparam int PAIRW = LW + 1;
    localparam int SUMW  = LW + 2;
    localparam int USW   = LW + 1;
    localparam int ULW   = 21;
    localparam int UHW   = USW - ULW;
    localparam int PHW   = UHW + lnw_pkg::CFG_W;
    localparam int PLW   = ULW + lnw_pkg::CFG_W;
    localparam int ACCW  = PHW + ULW + 1;
    localparam int WW    = ACCW - lnw_pkg::ETA_FRAC;
    localparam int ND    = lnw_pkg::NUM_DIR;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_SUM,
        ST_MUL,
        ST_DONE
    } fin_state_t;

    fin_state_t                    state_reg;
    fin_state_t                    state_next;
    logic signed [LW-1:0]          lane_reg  [ND];
    logic signed [LW-1:0]          lane_next [ND];
    logic signed [LW-1:0]          term      [ND];
    logic signed [PAIRW-1:0]       px_reg;
    logic signed [PAIRW-1:0]       px_next;
    logic signed [PAIRW-1:0]       py_reg;
    logic signed [PAIRW-1:0]       py_next;
    logic [UHW-1:0]                uh_reg;
    logic [UHW-1:0]                uh_next;
    logic [ULW-1:0]                ul_reg;
    logic [ULW-1:0]                ul_next;
    logic [PHW-1:0]                pp_hi_reg;
    logic [PHW-1:0]                pp_hi_next;
    logic [PLW-1:0]                pp_lo_reg;
    logic [PLW-1:0]                pp_lo_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [lnw_pkg::WL_W-1:0]      m_wl_reg;
    logic [lnw_pkg::WL_W-1:0]      m_wl_next;
    logic                          m_ovf_reg;
    logic                          m_ovf_next;
    logic signed [SUMW-1:0]        total;
    logic [USW-1:0]                us;
    logic [ACCW-1:0]               acc;
    logic [WW-1:0]                 w;

    // max(a,b) + ln(1 + exp(-|a-b|)), saturated
    function automatic logic signed [LW-1:0] merge(input logic signed [LW-1:0] a,
                                                    input logic signed [LW-1:0] b);
        logic signed [LW:0]          diff;
        logic [LW:0]                 d;
        logic [LW:0]                 idx;
        logic signed [LW-1:0]        hi;
        logic [lnw_pkg::CORR_W-1:0]  c;
        logic signed [LW:0]          s;
        diff = (LW + 1)'(a) - (LW + 1)'(b);
        hi   = (a > b) ? a : b;
        d    = diff[LW] ? $unsigned(-diff) : $unsigned(diff);
        idx  = d >> lnw_pkg::STEP_SHIFT;
        if (idx < (LW + 1)'(lnw_pkg::CORR_DEPTH)) begin
            c = lnw_pkg::CORR_TAB[idx[lnw_pkg::CORR_IDX_W-1:0]];
        end else begin
            c = '0;
        end
        s = (LW + 1)'(hi) + $signed({{(LW + 1 - lnw_pkg::CORR_W){1'b0}}, c});
        if (s > $signed({1'b0, lnw_pkg::LSUM_MAX})) begin
            return $signed(lnw_pkg::LSUM_MAX);
        end
        return s[LW-1:0];
    endfunction

    assign pop = head_valid && (!head.last || state_reg == ST_IDLE);

    assign term[0] = head.vx;
    assign term[1] = -head.vx;
    assign term[2] = head.vy;
    assign term[3] = -head.vy;

    assign total = SUMW'(px_reg) + SUMW'(py_reg);
    assign us    = total[SUMW-1] ? '0 : total[USW-1:0];
    assign acc   = ACCW'({pp_hi_reg, {ULW{1'b0}}}) + ACCW'(pp_lo_reg);
    assign w     = acc[ACCW-1:lnw_pkg::ETA_FRAC];

    always_comb begin
        for (int i = 0; i < ND; i++) begin
            lane_next[i] = lane_reg[i];
            if (pop) begin
                lane_next[i] = head.first ? term[i] : merge(lane_reg[i], term[i]);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        uh_next      = uh_reg;
        ul_next      = ul_reg;
        pp_hi_next   = pp_hi_reg;
        pp_lo_next   = pp_lo_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_wl_next    = m_wl_reg;
        m_ovf_next   = m_ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && head.last) begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR: begin
                px_next    = PAIRW'(lane_reg[0]) + PAIRW'(lane_reg[1]);
                py_next    = PAIRW'(lane_reg[2]) + PAIRW'(lane_reg[3]);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                uh_next    = us[USW-1:ULW];
                ul_next    = us[ULW-1:0];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                pp_hi_next = PHW'(uh_reg) * PHW'(eta);
                pp_lo_next = PLW'(ul_reg) * PLW'(eta);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (|w[WW-1:lnw_pkg::WL_W]) begin
                        m_wl_next  = lnw_pkg::WL_MAX;
                        m_ovf_next = 1'b1;
                    end else begin
                        m_wl_next  = w[lnw_pkg::WL_W-1:0];
                        m_ovf_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        for (int i = 0; i < ND; i++) begin
            lane_reg[i] <= lane_next[i];
        end
        px_reg    <= px_next;
        py_reg    <= py_next;
        uh_reg    <= uh_next;
        ul_reg    <= ul_next;
        pp_hi_reg <= pp_hi_next;
        pp_lo_reg <= pp_lo_next;
        m_wl_reg  <= m_wl_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lnw_pkg::OUT_DATA_W'(m_wl_reg);
    assign m_tuser  = m_ovf_reg;

endmodule

// ----- rtl/lnw_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for lse_net_wirelength, bound to the top level.
// Depends on lnw_pkg.
module lnw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lnw_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [0:0]                      m_tuser
);

    logic [3:0] pend_reg;
    logic [3:0] pend_next;

    // nets closed at the input minus results transferred
    always_comb begin
        pend_next = pend_reg;
        if (s_tvalid && s_tready && s_tlast) begin
            pend_next = pend_next + 4'd1;
        end
        if (m_tvalid && m_tready) begin
            pend_next = pend_next - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 4'd0)
        else $error("result without a closed net");

    a_overflow_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[lnw_pkg::WL_W-1:0] == lnw_pkg::WL_MAX)
        else $error("overflow flagged with unsaturated wirelength");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

endmodule

bind lse_net_wirelength lnw_checker u_lnw_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lse_net_wirelength: streams pin nets under several eta settings
// and checks each net wirelength against an in-bench log-sum-exp predictor or a preset value.
// Depends on rtl/lnw_pkg.sv and rtl/lse_net_wirelength.sv.
module tb;

    localparam int          CW           = lnw_pkg::COORD_W;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          SETTLE       = 20;
    localparam int          PHASE_PINS   = 140;
    localparam longint      LSUM_LIM     = 64'd549755813887;
    localparam logic [63:0] WL_LIM       = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic [63:0] DECAY_Q30    = 64'd1040706261;
    localparam logic [63:0] LN2_Q30_K    = 64'd744261118;
    localparam logic signed [CW-1:0] C_MAX = 28'h7FF_FFFF;
    localparam logic signed [CW-1:0] C_MIN = 28'h800_0000;

    typedef struct packed {
        logic [lnw_pkg::WL_W-1:0] wl;
        logic                     ovf;
    } wl_result_t;

    typedef enum logic {ROW_PIN, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_BEAT, RX_HOLD} rx_mode_t;

    typedef struct {
        row_kind_t                 kind;
        logic signed [CW-1:0]      cx;
        logic signed [CW-1:0]      cy;
        logic                      last;
        logic                      typed;
        wl_result_t                res;
        lnw_pkg::cfg_idx_t         sel;
        logic [lnw_pkg::CFG_W-1:0] val;
    } stim_row_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [lnw_pkg::IN_DATA_W-1:0]      s_tdata   = '0;
    logic                               s_tlast   = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [lnw_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [0:0]                         cfg_index = '0;
    logic [lnw_pkg::CFG_W-1:0]          cfg_data  = '0;

    int          corr_lut [lnw_pkg::CORR_DEPTH];
    longint      logsum_dir [lnw_pkg::NUM_DIR];
    logic        net_in_progress;
    logic [31:0] eta_reg;
    logic [31:0] inv_eta_reg;

    wl_result_t  wl_expected [$];
    stim_row_t   directed_rows [$];
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    int          burst_left  = 0;
    logic        tx_bursty   = 1'b0;
    rx_mode_t    rx_mode     = RX_FREE;
    int          rx_tick     = 0;
    int          rx_hold     = 0;

    lse_net_wirelength i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ln(1 + exp(-i/32)) in Q.8, log2 by repeated squaring
    function automatic void build_corr_lut();
        logic [63:0] decay;
        logic [63:0] z;
        logic [63:0] lg;
        logic [63:0] ln_q8;
        decay = ONE_Q30;
        for (int i = 0; i < lnw_pkg::CORR_DEPTH; i++) begin
            z  = ONE_Q30 + decay;
            lg = '0;
            if (z >= 2 * ONE_Q30) begin
                lg[20] = 1'b1;
                z = z >> 1;
            end
            for (int k = 19; k >= 0; k--) begin
                z = (z * z) >> 30;
                if (z >= 2 * ONE_Q30) begin
                    lg[k] = 1'b1;
                    z = z >> 1;
                end
            end
            ln_q8 = (lg * LN2_Q30_K + (64'd1 << 41)) >> 42;
            corr_lut[i] = int'(ln_q8);
            decay = (decay * DECAY_Q30 + (64'd1 << 29)) >> 30;
        end
    endfunction

    function automatic longint scale_coord(logic signed [CW-1:0] c);
        logic [63:0] mag;
        logic [63:0] r;
        mag = c[CW-1] ? (64'h1000_0000 - {36'd0, c}) : {36'd0, c};
        r = (mag * {32'd0, inv_eta_reg} + (64'd1 << (lnw_pkg::SCALE_SHIFT - 1)))
            >> lnw_pkg::SCALE_SHIFT;
        if (r > LSUM_LIM) r = LSUM_LIM;
        return c[CW-1] ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint merge_lse(longint a, longint b);
        longint hi;
        longint d;
        longint s;
        hi = (a > b) ? a : b;
        d  = (a > b) ? a - b : b - a;
        s  = hi;
        if ((d >>> lnw_pkg::STEP_SHIFT) < lnw_pkg::CORR_DEPTH)
            s = hi + corr_lut[d >>> lnw_pkg::STEP_SHIFT];
        if (s > LSUM_LIM) s = LSUM_LIM;
        return s;
    endfunction

    function automatic logic wl_predict(logic signed [CW-1:0] cx,
                                        logic signed [CW-1:0] cy,
                                        logic last, output wl_result_t res);
        longint      term [lnw_pkg::NUM_DIR];
        longint      total;
        logic [63:0] us;
        logic [63:0] w;
        term[0] = scale_coord(cx);
        term[1] = -term[0];
        term[2] = scale_coord(cy);
        term[3] = -term[2];
        for (int i = 0; i < lnw_pkg::NUM_DIR; i++)
            logsum_dir[i] = net_in_progress ? merge_lse(logsum_dir[i], term[i]) : term[i];
        res = '0;
        net_in_progress = !last;
        if (!last) return 1'b0;
        total = 0;
        for (int i = 0; i < lnw_pkg::NUM_DIR; i++) total += logsum_dir[i];
        if (total < 0) total = 0;
        us = total;
        w  = us * eta_reg[31:16] + ((us * eta_reg[15:0]) >> 16);
        if (w > WL_LIM) begin
            res.wl  = '1;
            res.ovf = 1'b1;
        end else begin
            res.wl  = w[lnw_pkg::WL_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t pin_row(logic signed [CW-1:0] cx,
                                          logic signed [CW-1:0] cy, logic last);
        stim_row_t r;
        r = '{kind: ROW_PIN, cx: cx, cy: cy, last: last, typed: 1'b0, res: '0,
              sel: lnw_pkg::CFG_ETA, val: '0};
        return r;
    endfunction

    function automatic stim_row_t pin_row_wl(logic signed [CW-1:0] cx,
                                             logic signed [CW-1:0] cy,
                                             logic [lnw_pkg::WL_W-1:0] wl, logic ovf);
        stim_row_t r;
        r = pin_row(cx, cy, 1'b1);
        r.typed  = 1'b1;
        r.res.wl = wl;
        r.res.ovf = ovf;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(lnw_pkg::cfg_idx_t sel,
                                          logic [lnw_pkg::CFG_W-1:0] val);
        stim_row_t r;
        r = pin_row('0, '0, 1'b0);
        r.kind = ROW_CFG;
        r.sel  = sel;
        r.val  = val;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(int style,
                                                        logic signed [CW-1:0] base);
        int span;
        int off;
        span = $urandom_range(1, 13);
        off  = $urandom_range(0, (1 << span) - 1) - (1 << (span - 1));
        case (style)
            6, 7:    return CW'($urandom);
            8: begin
                case ($urandom_range(0, 4))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    3:       return CW'(-1);
                    default: return CW'(1);
                endcase
            end
            9:       return CW'($urandom_range(0, 255) - 128);
            default: return CW'(base + off);
        endcase
    endfunction

    task automatic send_pin(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                            logic last, logic typed, wl_result_t typed_res);
        wl_result_t res;
        if (tx_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            repeat ($urandom_range(1, 12)) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {{(lnw_pkg::IN_DATA_W - 2 * CW){1'b0}}, cy, cx};
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        if (wl_predict(cx, cy, last, res)) wl_expected.push_back(typed ? typed_res : res);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic write_reg(lnw_pkg::cfg_idx_t sel, logic [lnw_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        burst_left = 0;
        while (wl_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = sel;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (sel == lnw_pkg::CFG_ETA) eta_reg = val;
        else inv_eta_reg = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random_nets(int pins);
        int                   sent;
        int                   len;
        int                   style;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        sent = 0;
        while (sent < pins) begin
            case ($urandom_range(0, 19))
                0:          len = $urandom_range(21, 40);
                1, 2, 3, 4: len = $urandom_range(7, 20);
                default:    len = $urandom_range(1, 6);
            endcase
            style = $urandom_range(0, 9);
            bx = CW'($urandom);
            by = CW'($urandom);
            for (int k = 0; k < len; k++) begin
                send_pin(pick_coord(style, bx), pick_coord(style, by), k == len - 1,
                         1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(negedge aclk) begin
        rx_tick = rx_tick + 1;
        case (rx_mode)
            RX_FREE: m_tready = 1'b1;
            RX_COIN: m_tready = ($urandom_range(0, 3) != 0);
            RX_BEAT: m_tready = ((rx_tick % 9) > 3);
            default: begin
                if (rx_hold != 0) begin
                    rx_hold = rx_hold - 1;
                    m_tready = 1'b0;
                end else begin
                    m_tready = 1'b1;
                    if ($urandom_range(0, 19) == 0) rx_hold = $urandom_range(4, 40);
                end
            end
        endcase
    end

    always @(posedge aclk) begin : result_check
        wl_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (wl_expected.size() == 0) begin
                $error("unexpected result transfer: net_wirelength %0d overflow %0d",
                       m_tdata[lnw_pkg::WL_W-1:0], m_tuser[0]);
                mismatches++;
            end else begin
                due = wl_expected.pop_front();
                if (m_tdata[lnw_pkg::WL_W-1:0] !== due.wl) begin
                    $error("net_wirelength: expected %0d, actual %0d",
                           due.wl, m_tdata[lnw_pkg::WL_W-1:0]);
                    mismatches++;
                end
                if (m_tuser[0] !== due.ovf) begin
                    $error("overflow: expected %0d, actual %0d", due.ovf, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        build_corr_lut();
        for (int i = 0; i < lnw_pkg::NUM_DIR; i++) logsum_dir[i] = 0;
        net_in_progress = 1'b0;
        eta_reg     = 32'd65536;
        inv_eta_reg = 32'd65536;

        directed_rows = '{
            pin_row_wl(0, 0, 0, 1'b0),
            pin_row_wl(C_MAX, C_MIN, 0, 1'b0),
            pin_row_wl(C_MIN, C_MAX, 0, 1'b0),
            // coincident pins: each direction gains ln 2
            pin_row(100, 200, 1'b0), pin_row_wl(100, 200, 708, 1'b0),
            pin_row(0, 0, 1'b0), pin_row(C_MAX, C_MAX, 1'b1),
            pin_row(0, 0, 1'b0), pin_row(80, -2400, 1'b0), pin_row(5, 5, 1'b0),
            pin_row(-1, 1, 1'b1),
            pin_row(C_MIN, C_MIN, 1'b0), pin_row(C_MAX, C_MAX, 1'b0),
            pin_row(C_MIN, C_MAX, 1'b1),
            cfg_row(lnw_pkg::CFG_ETA, 32'hFFFF_FFFF),
            cfg_row(lnw_pkg::CFG_INV_ETA, 32'hFFFF_FFFF),
            pin_row(C_MAX, C_MAX, 1'b0), pin_row_wl(C_MIN, C_MIN, lnw_pkg::WL_MAX, 1'b1),
            pin_row(C_MAX, C_MAX, 1'b0), pin_row(C_MAX, C_MAX, 1'b1),
            pin_row_wl(1, -1, 0, 1'b0),
            cfg_row(lnw_pkg::CFG_INV_ETA, 32'h0),
            pin_row(C_MAX, C_MIN, 1'b0), pin_row(-77, 12345, 1'b1),
            cfg_row(lnw_pkg::CFG_ETA, 32'h0),
            pin_row(C_MAX, 3, 1'b0), pin_row_wl(9, C_MIN, 0, 1'b0),
            cfg_row(lnw_pkg::CFG_ETA, 32'h1), cfg_row(lnw_pkg::CFG_INV_ETA, 32'h1),
            pin_row(C_MAX, C_MAX, 1'b0), pin_row(-500, 500, 1'b1)
        };

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        tx_bursty = 1'b1;
        rx_mode   = RX_COIN;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].sel, directed_rows[i].val);
            else
                send_pin(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].last,
                         directed_rows[i].typed, directed_rows[i].res);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(lnw_pkg::CFG_ETA, 32'h0001_0000);
                    write_reg(lnw_pkg::CFG_INV_ETA, 32'h0001_0000);
                    tx_bursty = 1'b0;
                    rx_mode   = RX_FREE;
                end
                1: begin
                    write_reg(lnw_pkg::CFG_ETA, 32'hFFFF_FFFF);
                    write_reg(lnw_pkg::CFG_INV_ETA, 32'hFFFF_FFFF);
                    tx_bursty = 1'b1;
                    rx_mode   = RX_COIN;
                end
                2: begin
                    write_reg(lnw_pkg::CFG_ETA, 32'h1);
                    write_reg(lnw_pkg::CFG_INV_ETA, 32'h1);
                    tx_bursty = 1'b1;
                    rx_mode   = RX_BEAT;
                end
                3: begin
                    write_reg(lnw_pkg::CFG_ETA, $urandom);
                    write_reg(lnw_pkg::CFG_INV_ETA, $urandom);
                    tx_bursty = 1'b1;
                    rx_mode   = RX_HOLD;
                end
                4: begin
                    write_reg(lnw_pkg::CFG_ETA, 32'h0004_0000);
                    write_reg(lnw_pkg::CFG_INV_ETA, 32'h0000_4000);
                    tx_bursty = 1'b0;
                    rx_mode   = RX_COIN;
                end
                default: begin
                    write_reg(lnw_pkg::CFG_ETA, $urandom_range(1, 32'h0004_0000));
                    write_reg(lnw_pkg::CFG_INV_ETA,
                              $urandom_range(32'h0000_8000, 32'h0002_0000));
                    tx_bursty = 1'b1;
                    rx_mode   = RX_HOLD;
                end
            endcase
            run_random_nets(PHASE_PINS);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (wl_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
